>>> rtl/bvia_pkg.sv
package bvia_pkg;

  localparam int WIDTH = 32;
  localparam int CW    = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_AND  = 5'd4,  OP_OR   = 5'd5,  OP_XOR  = 5'd6,  OP_NAND = 5'd7,
    OP_NOR  = 5'd8,  OP_XNOR = 5'd9,  OP_NOT  = 5'd10, OP_NEG  = 5'd11,
    OP_INC  = 5'd12, OP_DEC  = 5'd13, OP_SHL  = 5'd14, OP_SHR  = 5'd15,
    OP_ROL  = 5'd16, OP_ROR  = 5'd17, OP_GT   = 5'd18, OP_LT   = 5'd19,
    OP_GE   = 5'd20, OP_LE   = 5'd21, OP_EQ   = 5'd22
  } op_t;

  // one beat as it travels down the row of divide cells
  typedef struct packed {
    word_t result;   // final value, or quotient bits being built
    word_t dvd;      // dividend, consumed msb first
    word_t dvs;      // divisor
    word_t rem;      // partial remainder
    logic  cmp;
    logic  dz;
    logic  is_div;
  } beat_t;

endpackage

>>> rtl/bit_vector_integer_alu.sv
// integer alu: add, sub, mul, unsigned div, logic, shifts, rotates, compares
//
// input channel: in_valid / in_stall with op, operand_a, operand_b,
// shift_count, signed_mode. a beat is taken when in_valid is high and
// in_stall low. output channel: out_valid / out_stall with result_value,
// compare_true, divide_by_zero, one result beat per input beat, in order.
//
// every beat walks a row of WIDTH identical cells, one per cycle unless
// stalled; each cell does one restoring divide step, other ops ride along
// unchanged. throughput is one beat per cycle while out_stall is low, set
// by the row. the last cell is the output register.
//
// stall: each cell loads when it is empty or its successor moves, so
// bubbles close up and new beats are taken while a finished result waits;
// in_stall rises only when the whole row is full and out_stall is high.
// reset empties the row; nothing else is kept between beats.
module bit_vector_integer_alu import bvia_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [4:0]    op,
  input  word_t         operand_a,
  input  word_t         operand_b,
  input  logic [CW-1:0] shift_count,
  input  logic          signed_mode,
  output logic          out_valid,
  input  logic          out_stall,
  output word_t         result_value,
  output logic          compare_true,
  output logic          divide_by_zero
);

  beat_t front_beat;
  // chain links: index i feeds cell i
  logic  lnk_valid [WIDTH+1];
  beat_t lnk_beat  [WIDTH+1];
  logic  lnk_ready [WIDTH+1];

  // decode and the combinational ops, multiply included
  bvia_front u_front (
    .op          (op),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .shift_count (shift_count),
    .signed_mode (signed_mode),
    .beat        (front_beat)
  );

  assign lnk_valid[0]     = in_valid;
  assign lnk_beat[0]      = front_beat;
  assign lnk_ready[WIDTH] = !out_stall;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bvia_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (lnk_valid[i]),
      .up_beat  (lnk_beat[i]),
      .dn_ready (lnk_ready[i+1]),
      .ready    (lnk_ready[i]),
      .valid    (lnk_valid[i+1]),
      .beat     (lnk_beat[i+1])
    );
  end

  assign in_stall       = !lnk_ready[0];
  assign out_valid      = lnk_valid[WIDTH];
  assign result_value   = lnk_beat[WIDTH].result;
  assign compare_true   = lnk_beat[WIDTH].cmp;
  assign divide_by_zero = lnk_beat[WIDTH].dz;

endmodule

>>> rtl/bvia_front.sv
module bvia_front import bvia_pkg::*; (
  input  logic [4:0]    op,
  input  word_t         operand_a,
  input  word_t         operand_b,
  input  logic [CW-1:0] shift_count,
  input  logic          signed_mode,
  output beat_t         beat
);

  word_t                a_key;
  word_t                b_key;
  logic [2*WIDTH-1:0]   dbl;
  logic [2*WIDTH-1:0]   rol_w;
  logic [2*WIDTH-1:0]   ror_w;

  assign a_key = signed_mode ? (operand_a ^ {1'b1, {(WIDTH-1){1'b0}}}) : operand_a;
  assign b_key = signed_mode ? (operand_b ^ {1'b1, {(WIDTH-1){1'b0}}}) : operand_b;
  assign dbl   = {operand_a, operand_a};
  assign rol_w = dbl << shift_count;
  assign ror_w = dbl >> shift_count;

  always_comb begin
    beat        = '0;
    beat.dvd    = operand_a;
    beat.dvs    = operand_b;
    unique case (op)
      OP_ADD:  beat.result = operand_a + operand_b;
      OP_SUB:  beat.result = operand_a - operand_b;
      OP_MUL:  beat.result = operand_a * operand_b;
      OP_DIV: begin
        if (operand_b == '0) begin
          beat.result = '1;
          beat.dz     = 1'b1;
        end else begin
          beat.is_div = 1'b1;
        end
      end
      OP_AND:  beat.result = operand_a & operand_b;
      OP_OR:   beat.result = operand_a | operand_b;
      OP_XOR:  beat.result = operand_a ^ operand_b;
      OP_NAND: beat.result = ~(operand_a & operand_b);
      OP_NOR:  beat.result = ~(operand_a | operand_b);
      OP_XNOR: beat.result = ~(operand_a ^ operand_b);
      OP_NOT:  beat.result = ~operand_a;
      OP_NEG:  beat.result = '0 - operand_a;
      OP_INC:  beat.result = operand_a + word_t'(1);
      OP_DEC:  beat.result = operand_a - word_t'(1);
      OP_SHL:  beat.result = operand_a << shift_count;
      OP_SHR:  beat.result = signed_mode ? word_t'($signed(operand_a) >>> shift_count)
                                         : (operand_a >> shift_count);
      OP_ROL:  beat.result = rol_w[2*WIDTH-1:WIDTH];
      OP_ROR:  beat.result = ror_w[WIDTH-1:0];
      OP_GT:   beat.cmp = a_key > b_key;
      OP_LT:   beat.cmp = a_key < b_key;
      OP_GE:   beat.cmp = a_key >= b_key;
      OP_LE:   beat.cmp = a_key <= b_key;
      OP_EQ:   beat.cmp = operand_a == operand_b;
      default: beat = '0;
    endcase
  end

endmodule

>>> rtl/bvia_cell.sv
module bvia_cell import bvia_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  input  beat_t up_beat,
  input  logic  dn_ready,
  output logic  ready,
  output logic  valid,
  output beat_t beat
);

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  beat_t          beat_next;

  assign ready = !valid || dn_ready;

  // one restoring divide step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial     = {up_beat.rem, up_beat.dvd[WIDTH-1]};
    diff      = trial - {1'b0, up_beat.dvs};
    beat_next = up_beat;
    if (up_beat.is_div) begin
      beat_next.dvd    = up_beat.dvd << 1;
      beat_next.rem    = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
      beat_next.result = {up_beat.result[WIDTH-2:0], !diff[WIDTH]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      beat <= beat_next;
    end
  end

endmodule

>>> rtl/bvia_checker.sv
module bvia_checker import bvia_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input word_t result_value,
  input logic  compare_true,
  input logic  divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_value) && $stable(compare_true)
                                && $stable(divide_by_zero))
    else $error("stalled output changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled while the row can move");

  a_dz_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == '1 && !compare_true)
    else $error("divide by zero result malformed");

endmodule

bind bit_vector_integer_alu bvia_checker u_bvia_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .result_value   (result_value),
  .compare_true   (compare_true),
  .divide_by_zero (divide_by_zero)
);
